[rtl/qau_pkg.sv]
// Shared types, constants and fixed-point helpers for the quaternion arithmetic unit.
// Used by every other file of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package qau_pkg;

   localparam int FRAC_BITS   = 12;
   localparam int WORD_BITS   = 16;
   localparam int PROD_W      = 2 * WORD_BITS;
   localparam int ACC_W       = PROD_W + 3;
   localparam int SQ_W        = PROD_W + 2;
   localparam int ROOT_STEPS  = WORD_BITS + 1;
   localparam int LEN_W       = WORD_BITS + 2;
   localparam int QUO_BITS    = WORD_BITS + 1;
   localparam int DIV_W       = 2 * WORD_BITS + FRAC_BITS + 4;
   localparam int CNT_W       = $clog2(WORD_BITS + 2);
   localparam int NUM_PROD    = 16;
   localparam int QUEUE_DEPTH = 2;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [PROD_W-1:0]    prod_type;
   typedef logic signed [ACC_W-1:0]     acc_type;
   typedef logic [3:0]                  cmd_type;

   localparam cmd_type CMD_MUL       = 4'd0;
   localparam cmd_type CMD_ADD       = 4'd1;
   localparam cmd_type CMD_SUB       = 4'd2;
   localparam cmd_type CMD_CONJ      = 4'd3;
   localparam cmd_type CMD_SCALE     = 4'd4;
   localparam cmd_type CMD_DIVIDE    = 4'd5;
   localparam cmd_type CMD_LENGTH    = 4'd6;
   localparam cmd_type CMD_NORMALIZE = 4'd7;
   localparam cmd_type CMD_MATRIX    = 4'd8;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SAT  = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;

   localparam acc_type ACC_HALF = acc_type'(64'd1 << (FRAC_BITS - 1));
   localparam acc_type ACC_ONE  = acc_type'(64'd1 << FRAC_BITS);
   localparam acc_type ACC_WMAX = acc_type'((64'd1 << (WORD_BITS - 1)) - 64'd1);
   localparam acc_type ACC_WMIN = ~ACC_WMAX;

   // Highest even bit position the square root can reach: 4 * (2^(W-1))^2.
   localparam logic [SQ_W-1:0] SQ_TOP = {2'b01, {(2 * WORD_BITS){1'b0}}};

   typedef struct packed {
      logic [3:0] command;
      word_type   a_w;
      word_type   a_x;
      word_type   a_y;
      word_type   a_z;
      word_type   b_w;
      word_type   b_x;
      word_type   b_y;
      word_type   b_z;
      word_type   factor;
   } req_payload_type;

   typedef struct packed {
      word_type   out_w;
      word_type   out_x;
      word_type   out_y;
      word_type   out_z;
      logic [1:0] status;
      logic       last;
   } rsp_payload_type;

   typedef struct packed {
      cmd_type        op;
      word_type [3:0] a;
      word_type [3:0] b;
      word_type       f;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

   typedef struct packed {
      logic     hit;
      word_type value;
   } sat_type;

   function automatic acc_type ext_word(input word_type v);
      return {{(ACC_W - WORD_BITS){v[WORD_BITS-1]}}, v};
   endfunction

   function automatic acc_type ext_prod(input prod_type v);
      return {{(ACC_W - PROD_W){v[PROD_W-1]}}, v};
   endfunction

   // Round to nearest, ties toward plus infinity, dropping the fraction bits.
   function automatic acc_type round_frac(input acc_type v);
      acc_type t;
      t = v + ACC_HALF;
      return t >>> FRAC_BITS;
   endfunction

   function automatic sat_type sat_word(input acc_type v);
      sat_type s;
      s.hit   = 1'b0;
      s.value = v[WORD_BITS-1:0];
      if (v > ACC_WMAX) begin
         s.hit   = 1'b1;
         s.value = {1'b0, {(WORD_BITS - 1){1'b1}}};
      end else if (v < ACC_WMIN) begin
         s.hit   = 1'b1;
         s.value = {1'b1, {(WORD_BITS - 1){1'b0}}};
      end
      return s;
   endfunction

endpackage

`default_nettype wire

[rtl/qau_req_if.sv]
// Valid/ready channel interfaces for the request and response sides of the unit.
// Depends on qau_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface qau_req_if;
   import qau_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface qau_rsp_if;
   import qau_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/qau_front.sv]
// Front end: accepts request transactions, drops unknown commands and forms queue items.
// Depends on qau_pkg and the channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module qau_front (
   qau_req_if.sink            req_ch,
   output qau_pkg::push_type  push,
   input  logic               push_ready
);
   import qau_pkg::*;

   logic cmd_known;

   assign cmd_known    = (req_ch.payload.command <= CMD_MATRIX);
   assign req_ch.ready = push_ready;

   // Unknown commands are consumed here and never reach the back end.
   assign push.valid  = req_ch.valid && cmd_known;
   assign push.item.op = req_ch.payload.command;
   assign push.item.a  = {req_ch.payload.a_z, req_ch.payload.a_y,
                          req_ch.payload.a_x, req_ch.payload.a_w};
   assign push.item.b  = {req_ch.payload.b_z, req_ch.payload.b_y,
                          req_ch.payload.b_x, req_ch.payload.b_w};
   assign push.item.f  = req_ch.payload.factor;

endmodule

`default_nettype wire

[rtl/qau_queue.sv]
// Short FIFO between the front and back ends of the quaternion unit.
// Depends on qau_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none

module qau_queue (
   input  logic               clock,
   input  logic               reset,
   input  qau_pkg::push_type  push,
   output logic               push_ready,
   output logic               pop_valid,
   output qau_pkg::item_type  pop_item,
   input  logic               pop_ready
);
   import qau_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_Q = $clog2(QUEUE_DEPTH + 1);

   item_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_Q-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_Q'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_Q'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_Q'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

`default_nettype wire

[rtl/qau_back.sv]
// Back end: product array, square-root and division sequencer, result formatting
// and the output register. Depends on qau_pkg and the channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module qau_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  qau_pkg::item_type pop_item,
   output logic              pop_ready,
   qau_rsp_if.source         rsp_ch
);
   import qau_pkg::*;

   localparam logic [2:0] PH_DONE      = 3'd0;
   localparam logic [2:0] PH_SQRT_INIT = 3'd1;
   localparam logic [2:0] PH_SQRT      = 3'd2;
   localparam logic [2:0] PH_SQRT_END  = 3'd3;
   localparam logic [2:0] PH_DIV_INIT  = 3'd4;
   localparam logic [2:0] PH_DIV       = 3'd5;

   // Stage registers holding the item under work.
   logic              s1_valid_ff, s1_valid_in;
   cmd_type           s1_op_ff;
   word_type [3:0]    s1_a_ff;
   word_type [3:0]    s1_b_ff;
   logic              s1_fneg_ff;
   logic              s1_zero_ff;
   prod_type          s1_prod_ff [NUM_PROD];
   prod_type          prod_in    [NUM_PROD];
   logic [2:0]        phase_ff, phase_in;
   logic [1:0]        row_ff, row_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // Square-root and division working registers.
   logic [SQ_W-1:0]   rem_ff, rem_in;
   logic [SQ_W-1:0]   root_ff, root_in;
   logic [SQ_W-1:0]   sqbit_ff, sqbit_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  dd_ff, dd_in;
   logic [DIV_W-1:0]  dv_ff, dv_in;
   logic [DIV_W-1:0]  drem_ff [4];
   logic [DIV_W-1:0]  drem_in [4];
   logic [QUO_BITS-1:0] quo_ff [4];
   logic [QUO_BITS-1:0] quo_in [4];
   logic [3:0]        neg_ff, neg_in;
   logic [3:0]        ov_ff, ov_in;

   rsp_payload_type   rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;

   word_type          mu [NUM_PROD];
   word_type          mv [NUM_PROD];
   logic              load_s1, load_out, is_last, release_s1;
   logic [LEN_W-1:0]  fabs;
   rsp_payload_type   result;

   assign load_out   = s1_valid_ff && (phase_ff == PH_DONE) &&
                       (!rsp_valid_ff || rsp_ch.ready);
   assign is_last    = (s1_op_ff != CMD_MATRIX) || (row_ff == 2'd2);
   assign release_s1 = load_out && is_last;
   assign pop_ready  = !s1_valid_ff || release_s1;
   assign load_s1    = pop_valid && pop_ready;
   assign fabs       = pop_item.f[WORD_BITS-1] ?
                       LEN_W'(-ext_word(pop_item.f)) : LEN_W'(ext_word(pop_item.f));

   // Multiplier operand routing, straight from the queue head.
   always_comb begin
      for (int i = 0; i < NUM_PROD; i++) begin
         mu[i] = '0;
         mv[i] = '0;
      end
      case (pop_item.op)
         CMD_MUL: begin
            mu[0]  = pop_item.a[0]; mv[0]  = pop_item.b[0];
            mu[1]  = pop_item.a[1]; mv[1]  = pop_item.b[1];
            mu[2]  = pop_item.a[2]; mv[2]  = pop_item.b[2];
            mu[3]  = pop_item.a[3]; mv[3]  = pop_item.b[3];
            mu[4]  = pop_item.a[0]; mv[4]  = pop_item.b[1];
            mu[5]  = pop_item.a[1]; mv[5]  = pop_item.b[0];
            mu[6]  = pop_item.a[2]; mv[6]  = pop_item.b[3];
            mu[7]  = pop_item.a[3]; mv[7]  = pop_item.b[2];
            mu[8]  = pop_item.a[0]; mv[8]  = pop_item.b[2];
            mu[9]  = pop_item.a[2]; mv[9]  = pop_item.b[0];
            mu[10] = pop_item.a[3]; mv[10] = pop_item.b[1];
            mu[11] = pop_item.a[1]; mv[11] = pop_item.b[3];
            mu[12] = pop_item.a[0]; mv[12] = pop_item.b[3];
            mu[13] = pop_item.a[3]; mv[13] = pop_item.b[0];
            mu[14] = pop_item.a[1]; mv[14] = pop_item.b[2];
            mu[15] = pop_item.a[2]; mv[15] = pop_item.b[1];
         end
         CMD_SCALE: begin
            for (int k = 0; k < 4; k++) begin
               mu[4 * k] = pop_item.a[k];
               mv[4 * k] = pop_item.f;
            end
         end
         CMD_LENGTH, CMD_NORMALIZE: begin
            for (int k = 0; k < 4; k++) begin
               mu[k] = pop_item.a[k];
               mv[k] = pop_item.a[k];
            end
         end
         CMD_MATRIX: begin
            // yy, zz, xy, wz, xz, wy, xx, yz, wx
            mu[0] = pop_item.a[2]; mv[0] = pop_item.a[2];
            mu[1] = pop_item.a[3]; mv[1] = pop_item.a[3];
            mu[2] = pop_item.a[1]; mv[2] = pop_item.a[2];
            mu[3] = pop_item.a[0]; mv[3] = pop_item.a[3];
            mu[4] = pop_item.a[1]; mv[4] = pop_item.a[3];
            mu[5] = pop_item.a[0]; mv[5] = pop_item.a[2];
            mu[6] = pop_item.a[1]; mv[6] = pop_item.a[1];
            mu[7] = pop_item.a[2]; mv[7] = pop_item.a[3];
            mu[8] = pop_item.a[0]; mv[8] = pop_item.a[1];
         end
         default: begin
         end
      endcase
      for (int i = 0; i < NUM_PROD; i++) begin
         prod_in[i] = mu[i] * mv[i];
      end
   end

   // Stage control and the square-root / division sequencer.
   always_comb begin
      logic [SQ_W-1:0]         trial;
      logic [DIV_W-1:0]        dd2;
      logic signed [DIV_W-1:0] nn;
      acc_type                 sq_sum;

      s1_valid_in = s1_valid_ff;
      phase_in    = phase_ff;
      row_in      = row_ff;
      cnt_in      = cnt_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      sqbit_in    = sqbit_ff;
      len_in      = len_ff;
      dd_in       = dd_ff;
      dv_in       = dv_ff;
      neg_in      = neg_ff;
      ov_in       = ov_ff;
      for (int k = 0; k < 4; k++) begin
         drem_in[k] = drem_ff[k];
         quo_in[k]  = quo_ff[k];
      end
      trial  = root_ff + sqbit_ff;
      dd2    = {{(DIV_W - LEN_W - 1){1'b0}}, dd_ff, 1'b0};
      sq_sum = ext_prod(s1_prod_ff[0]) + ext_prod(s1_prod_ff[1]) +
               ext_prod(s1_prod_ff[2]) + ext_prod(s1_prod_ff[3]);
      nn     = '0;

      if (load_out && !is_last) begin
         row_in = row_ff + 2'd1;
      end
      if (release_s1) begin
         s1_valid_in = 1'b0;
      end

      case (phase_ff)
         PH_SQRT_INIT: begin
            rem_in   = sq_sum[SQ_W-1:0];
            root_in  = '0;
            sqbit_in = SQ_TOP;
            cnt_in   = CNT_W'(ROOT_STEPS - 1);
            phase_in = PH_SQRT;
         end
         PH_SQRT: begin
            if (rem_ff >= trial) begin
               rem_in  = rem_ff - trial;
               root_in = (root_ff >> 1) + sqbit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            sqbit_in = sqbit_ff >> 2;
            cnt_in   = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               phase_in = PH_SQRT_END;
            end
         end
         PH_SQRT_END: begin
            // Round the root up when the remainder exceeds it.
            len_in = root_ff[LEN_W-1:0] + LEN_W'(rem_ff > root_ff);
            dd_in  = len_in;
            phase_in = (s1_op_ff == CMD_LENGTH) ? PH_DONE : PH_DIV_INIT;
         end
         PH_DIV_INIT: begin
            for (int k = 0; k < 4; k++) begin
               nn = $signed({{(DIV_W - WORD_BITS){s1_a_ff[k][WORD_BITS-1]}}, s1_a_ff[k]})
                    <<< (FRAC_BITS + 1);
               if (s1_fneg_ff) begin
                  nn = -nn;
               end
               nn = nn + $signed(DIV_W'(dd_ff));
               neg_in[k] = nn[DIV_W-1];
               // Floor of a negative quotient: take the ceiling of the magnitude.
               drem_in[k] = nn[DIV_W-1] ? (DIV_W'(-nn) + dd2 - DIV_W'(1)) : DIV_W'(nn);
               ov_in[k]   = drem_in[k] >= (dd2 << QUO_BITS);
               quo_in[k]  = '0;
            end
            dv_in    = dd2 << (QUO_BITS - 1);
            cnt_in   = CNT_W'(QUO_BITS - 1);
            phase_in = PH_DIV;
         end
         PH_DIV: begin
            for (int k = 0; k < 4; k++) begin
               if (drem_ff[k] >= dv_ff) begin
                  drem_in[k] = drem_ff[k] - dv_ff;
                  quo_in[k]  = {quo_ff[k][QUO_BITS-2:0], 1'b1};
               end else begin
                  quo_in[k]  = {quo_ff[k][QUO_BITS-2:0], 1'b0};
               end
            end
            dv_in  = dv_ff >> 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               phase_in = PH_DONE;
            end
         end
         default: begin
         end
      endcase

      if (load_s1) begin
         s1_valid_in = 1'b1;
         row_in      = '0;
         dd_in       = fabs;
         case (pop_item.op)
            CMD_LENGTH: begin
               phase_in = PH_SQRT_INIT;
            end
            CMD_NORMALIZE: begin
               phase_in = (pop_item.a == '0) ? PH_DONE : PH_SQRT_INIT;
            end
            CMD_DIVIDE: begin
               phase_in = (pop_item.f == '0) ? PH_DONE : PH_DIV_INIT;
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end
   end

   // Result formatting for the current row of the item in the stage.
   always_comb begin
      acc_type r [4];
      acc_type pe [NUM_PROD];
      acc_type qv;
      sat_type s;
      logic    any_sat;

      for (int i = 0; i < NUM_PROD; i++) begin
         pe[i] = ext_prod(s1_prod_ff[i]);
      end
      for (int k = 0; k < 4; k++) begin
         r[k] = '0;
      end
      qv = '0;

      case (s1_op_ff)
         CMD_MUL: begin
            r[0] = round_frac(pe[0] - pe[1] - pe[2] - pe[3]);
            for (int k = 1; k < 4; k++) begin
               r[k] = round_frac(pe[4 * k] + pe[4 * k + 1] + pe[4 * k + 2] - pe[4 * k + 3]);
            end
         end
         CMD_ADD: begin
            for (int k = 0; k < 4; k++) begin
               r[k] = ext_word(s1_a_ff[k]) + ext_word(s1_b_ff[k]);
            end
         end
         CMD_SUB: begin
            for (int k = 0; k < 4; k++) begin
               r[k] = ext_word(s1_a_ff[k]) - ext_word(s1_b_ff[k]);
            end
         end
         CMD_CONJ: begin
            r[0] = ext_word(s1_a_ff[0]);
            for (int k = 1; k < 4; k++) begin
               r[k] = -ext_word(s1_a_ff[k]);
            end
         end
         CMD_SCALE: begin
            for (int k = 0; k < 4; k++) begin
               r[k] = round_frac(pe[4 * k]);
            end
         end
         CMD_DIVIDE, CMD_NORMALIZE: begin
            if (!s1_zero_ff) begin
               for (int k = 0; k < 4; k++) begin
                  if (ov_ff[k]) begin
                     qv = neg_ff[k] ? (ACC_WMIN - acc_type'(1)) : (ACC_WMAX + acc_type'(1));
                  end else begin
                     qv = {{(ACC_W - QUO_BITS){1'b0}}, quo_ff[k]};
                     if (neg_ff[k]) begin
                        qv = -qv;
                     end
                  end
                  r[k] = qv;
               end
            end
         end
         CMD_LENGTH: begin
            r[0] = {{(ACC_W - LEN_W){1'b0}}, len_ff};
         end
         CMD_MATRIX: begin
            case (row_ff)
               2'd0: begin
                  r[1] = round_frac(-(pe[0] <<< 1) - (pe[1] <<< 1)) + ACC_ONE;
                  r[2] = round_frac((pe[2] <<< 1) - (pe[3] <<< 1));
                  r[3] = round_frac((pe[4] <<< 1) + (pe[5] <<< 1));
               end
               2'd1: begin
                  r[1] = round_frac((pe[2] <<< 1) + (pe[3] <<< 1));
                  r[2] = round_frac(-(pe[6] <<< 1) - (pe[1] <<< 1)) + ACC_ONE;
                  r[3] = round_frac((pe[7] <<< 1) - (pe[8] <<< 1));
               end
               default: begin
                  r[1] = round_frac((pe[4] <<< 1) - (pe[5] <<< 1));
                  r[2] = round_frac((pe[7] <<< 1) + (pe[8] <<< 1));
                  r[3] = round_frac(-(pe[6] <<< 1) - (pe[0] <<< 1)) + ACC_ONE;
               end
            endcase
         end
         default: begin
         end
      endcase

      any_sat = 1'b0;
      s = sat_word(r[0]); result.out_w = s.value; any_sat = any_sat | s.hit;
      s = sat_word(r[1]); result.out_x = s.value; any_sat = any_sat | s.hit;
      s = sat_word(r[2]); result.out_y = s.value; any_sat = any_sat | s.hit;
      s = sat_word(r[3]); result.out_z = s.value; any_sat = any_sat | s.hit;
      if (s1_zero_ff) begin
         result.status = ST_ZERO;
      end else if (any_sat) begin
         result.status = ST_SAT;
      end else begin
         result.status = ST_OK;
      end
      result.last = is_last;
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_data_in  = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         phase_ff     <= PH_DONE;
         row_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         phase_ff     <= phase_in;
         row_ff       <= row_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_s1) begin
         s1_op_ff   <= pop_item.op;
         s1_a_ff    <= pop_item.a;
         s1_b_ff    <= pop_item.b;
         s1_fneg_ff <= (pop_item.op == CMD_DIVIDE) && pop_item.f[WORD_BITS-1];
         s1_zero_ff <= ((pop_item.op == CMD_DIVIDE) && (pop_item.f == '0)) ||
                       ((pop_item.op == CMD_NORMALIZE) && (pop_item.a == '0));
         for (int i = 0; i < NUM_PROD; i++) begin
            s1_prod_ff[i] <= prod_in[i];
         end
      end
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      sqbit_ff <= sqbit_in;
      len_ff   <= len_in;
      dd_ff    <= dd_in;
      dv_ff    <= dv_in;
      neg_ff   <= neg_in;
      ov_ff    <= ov_in;
      for (int k = 0; k < 4; k++) begin
         drem_ff[k] <= drem_in[k];
         quo_ff[k]  <= quo_in[k];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/quaternion_arithmetic_unit.sv]
// Quaternion arithmetic unit in signed Q4.12: product, sum, difference, conjugate,
// scaling, division, length, normalization and rotation matrix. A front end takes a
// request transaction every cycle into a two-entry queue while that queue has room;
// the back end has a 16-lane multiplier array, a square-root and division sequencer
// and a response register. Product, add, subtract, conjugate and scale sustain one
// item per cycle while the response side is ready. The matrix command sends three row
// responses through the single response register, so it holds the stage until its
// last row is sent. Length runs a one-bit-per-cycle square root; divide runs 17
// restoring steps in four lanes; normalize runs both. Unknown commands are consumed
// without a response. The block has no state beyond its pipeline.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_arithmetic_unit (
   input  logic       clock,
   input  logic       reset,
   qau_req_if.sink    req_ch,
   qau_rsp_if.source  rsp_ch
);
   import qau_pkg::*;

   push_type push;
   logic     push_ready;
   logic     pop_valid;
   item_type pop_item;
   logic     pop_ready;

   qau_front u_front (
      .req_ch     (req_ch),
      .push       (push),
      .push_ready (push_ready)
   );

   qau_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   qau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

[sim/quaternion_arithmetic_unit_checker.sv]
// Checker for the quaternion arithmetic unit: watches both channels, predicts every
// response from each accepted request and compares them in order. Depends on qau_pkg.
`timescale 1ns / 1ps

module quaternion_arithmetic_unit_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  qau_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  qau_pkg::rsp_payload_type rsp_payload,
   output int                       error_count,
   output int                       pending_count
);
   import qau_pkg::*;

   localparam longint ONE  = 64'sd1 <<< FRAC_BITS;
   localparam longint WMAX = (64'sd1 <<< (WORD_BITS - 1)) - 1;
   localparam longint WMIN = -WMAX - 1;

   rsp_payload_type expected_rsps[$];

   // Floor division for a positive divisor.
   function automatic longint floor_div(input longint n, input longint d);
      if (n >= 0) return n / d;
      return -((-n + d - 1) / d);
   endfunction

   // Rounded fixed-point sum of weighted products plus an offset. The arithmetic
   // shift floors after half an LSB is added.
   function automatic longint fx_dot2(input longint u0, v0, c0, u1, v1, c1, offs);
      longint acc;
      acc = c0 * u0 * v0 + c1 * u1 * v1;
      return offs + ((acc + ONE / 2) >>> FRAC_BITS);
   endfunction

   function automatic longint fx_len(input longint q[4]);
      longint s, r, b;
      s = 0;
      for (int i = 0; i < 4; i++) s += q[i] * q[i];
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      // s now holds the remainder of the integer root.
      if (s > r) r++;
      return r;
   endfunction

   function automatic rsp_payload_type pack_rsp(input longint r[4], input logic [1:0] st,
                                                input logic lst);
      rsp_payload_type p;
      logic hit;
      word_type v[4];
      hit = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (r[i] > WMAX) begin
            v[i] = word_type'(WMAX); hit = 1'b1;
         end else if (r[i] < WMIN) begin
            v[i] = word_type'(WMIN); hit = 1'b1;
         end else begin
            v[i] = word_type'(r[i]);
         end
      end
      p.out_w = v[0]; p.out_x = v[1]; p.out_y = v[2]; p.out_z = v[3];
      p.status = (st == ST_OK && hit) ? ST_SAT : st;
      p.last = lst;
      return p;
   endfunction

   task automatic predict_quaternion(input req_payload_type q);
      longint a[4], b[4], r[4], m[9], f, d, len, w, x, y, z;
      logic [1:0] st;
      a = '{q.a_w, q.a_x, q.a_y, q.a_z};
      b = '{q.b_w, q.b_x, q.b_y, q.b_z};
      f = q.factor;
      r = '{0, 0, 0, 0};
      st = ST_OK;
      case (q.command)
         CMD_MUL: begin
            r[0] = ((a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]) + ONE/2) >>> FRAC_BITS;
            r[1] = ((a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]) + ONE/2) >>> FRAC_BITS;
            r[2] = ((a[0]*b[2] + a[2]*b[0] + a[3]*b[1] - a[1]*b[3]) + ONE/2) >>> FRAC_BITS;
            r[3] = ((a[0]*b[3] + a[3]*b[0] + a[1]*b[2] - a[2]*b[1]) + ONE/2) >>> FRAC_BITS;
         end
         CMD_ADD: for (int i = 0; i < 4; i++) r[i] = a[i] + b[i];
         CMD_SUB: for (int i = 0; i < 4; i++) r[i] = a[i] - b[i];
         CMD_CONJ: begin
            r[0] = a[0];
            for (int i = 1; i < 4; i++) r[i] = -a[i];
         end
         CMD_SCALE: for (int i = 0; i < 4; i++) r[i] = (a[i] * f + ONE/2) >>> FRAC_BITS;
         CMD_DIVIDE: begin
            if (f == 0) begin
               st = ST_ZERO;
            end else begin
               d = f < 0 ? -f : f;
               for (int i = 0; i < 4; i++)
                  r[i] = floor_div((f < 0 ? -a[i] : a[i]) * 2 * ONE + d, 2 * d);
            end
         end
         CMD_LENGTH: r[0] = fx_len(a);
         CMD_NORMALIZE: begin
            len = fx_len(a);
            if (len == 0) st = ST_ZERO;
            else for (int i = 0; i < 4; i++) r[i] = floor_div(a[i] * 2 * ONE + len, 2 * len);
         end
         CMD_MATRIX: begin
            w = a[0]; x = a[1]; y = a[2]; z = a[3];
            m[0] = fx_dot2(y, y, -2, z, z, -2, ONE);
            m[1] = fx_dot2(x, y, 2, w, z, -2, 0);
            m[2] = fx_dot2(x, z, 2, w, y, 2, 0);
            m[3] = fx_dot2(x, y, 2, w, z, 2, 0);
            m[4] = fx_dot2(x, x, -2, z, z, -2, ONE);
            m[5] = fx_dot2(y, z, 2, w, x, -2, 0);
            m[6] = fx_dot2(x, z, 2, w, y, -2, 0);
            m[7] = fx_dot2(y, z, 2, w, x, 2, 0);
            m[8] = fx_dot2(x, x, -2, y, y, -2, ONE);
            for (int i = 0; i < 3; i++) begin
               r = '{0, m[3*i], m[3*i+1], m[3*i+2]};
               expected_rsps.push_back(pack_rsp(r, ST_OK, i == 2));
            end
            return;
         end
         default: return;
      endcase
      expected_rsps.push_back(pack_rsp(r, st, 1'b1));
   endtask

   task automatic compare_rsp(input rsp_payload_type got);
      rsp_payload_type exp;
      if (expected_rsps.size() == 0) begin
         $error("unexpected response transaction %p", got);
         error_count++;
         return;
      end
      exp = expected_rsps.pop_front();
      if (got.out_w !== exp.out_w) begin
         $error("out_w expected %0d actual %0d", exp.out_w, got.out_w); error_count++;
      end
      if (got.out_x !== exp.out_x) begin
         $error("out_x expected %0d actual %0d", exp.out_x, got.out_x); error_count++;
      end
      if (got.out_y !== exp.out_y) begin
         $error("out_y expected %0d actual %0d", exp.out_y, got.out_y); error_count++;
      end
      if (got.out_z !== exp.out_z) begin
         $error("out_z expected %0d actual %0d", exp.out_z, got.out_z); error_count++;
      end
      if (got.status !== exp.status) begin
         $error("status expected %0d actual %0d", exp.status, got.status); error_count++;
      end
      if (got.last !== exp.last) begin
         $error("last expected %0d actual %0d", exp.last, got.last); error_count++;
      end
   endtask

   initial error_count = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) compare_rsp(rsp_payload);
         if (req_valid && req_ready) predict_quaternion(req_payload);
      end
   end

   assign pending_count = expected_rsps.size();

endmodule

[sim/quaternion_arithmetic_unit_tb.sv]
// Top of the quaternion arithmetic unit testbench: clock, reset, request stimulus,
// response back-pressure and verdict. Depends on qau_pkg, the channel interfaces and
// the checker module.
`timescale 1ns / 1ps

module quaternion_arithmetic_unit_tb;
   import qau_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count;
   int   pending_count;
   int   cycle_count = 0;
   int   hold_count = 0;
   logic long_hold = 1'b0;
   logic stimulus_done = 1'b0;

   qau_req_if req_ch();
   qau_rsp_if rsp_ch();

   quaternion_arithmetic_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   quaternion_arithmetic_unit_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_payload   (req_ch.payload),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_payload   (rsp_ch.payload),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
   end

   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   function automatic word_type rand_word();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sd0;
         3: return word_type'($urandom_range(0, 8192)) - 16'sd4096;
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic req_payload_type rand_item(input logic [3:0] op);
      req_payload_type p;
      p.command = op;
      p.a_w = rand_word(); p.a_x = rand_word(); p.a_y = rand_word(); p.a_z = rand_word();
      p.b_w = rand_word(); p.b_x = rand_word(); p.b_y = rand_word(); p.b_z = rand_word();
      p.factor = rand_word();
      return p;
   endfunction

   task automatic send_item(input req_payload_type p);
      req_ch.valid   <= 1'b1;
      req_ch.payload <= p;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_with_gap(input req_payload_type p);
      int g;
      g = gap_length();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      send_item(p);
   endtask

   // Response back-pressure: stalls of random length, and one long hold while
   // requests keep coming.
   always @(posedge clock) begin
      if (long_hold) begin
         rsp_ch.ready <= 1'b0;
      end else if (stimulus_done) begin
         rsp_ch.ready <= 1'b1;
      end else if (hold_count > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_count   <= hold_count - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_ch.ready <= 1'b0;
         hold_count   <= gap_length();
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      req_payload_type p;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed transactions: every command with extreme operands and the zero cases.
      p = '0;
      p.a_w = 16'sh7fff; p.a_x = 16'sh8000; p.a_y = 16'sh7fff; p.a_z = 16'sh8000;
      p.b_w = 16'sh8000; p.b_x = 16'sh8000; p.b_y = 16'sh7fff; p.b_z = 16'sh7fff;
      p.factor = 16'sh8000;
      for (int op = 0; op < 16; op++) begin
         p.command = 4'(op);
         send_item(p);
      end
      p = '0;
      p.a_w = 16'sh1000; p.factor = 16'sh0000;
      p.command = CMD_DIVIDE; send_item(p);
      p.a_w = 16'sh0000;
      p.command = CMD_NORMALIZE; send_item(p);
      p.command = CMD_LENGTH; send_item(p);
      p.command = CMD_MATRIX; send_item(p);
      p.a_w = 16'sh8000; p.a_x = 16'sh8000; p.a_y = 16'sh8000; p.a_z = 16'sh8000;
      p.command = CMD_NORMALIZE; send_item(p);
      p.factor = 16'sh0001;
      p.command = CMD_DIVIDE; send_item(p);
      p.factor = 16'shffff; send_item(p);

      // Pause until every response is back, then fill the block during a long hold.
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      fork
         begin
            long_hold <= 1'b1;
            repeat (60) @(posedge clock);
            long_hold <= 1'b0;
         end
         for (int i = 0; i < 8; i++) send_item(rand_item(4'($urandom_range(0, 4))));
      join

      for (int i = 0; i < 80; i++)
         send_with_gap(rand_item(4'(($urandom_range(0, 19) == 0) ? $urandom_range(9, 15)
                                                                   : $urandom_range(0, 8))));
      req_ch.valid <= 1'b0;
      stimulus_done <= 1'b1;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

[filelist.f]
rtl/qau_pkg.sv
rtl/qau_req_if.sv
rtl/qau_front.sv
rtl/qau_queue.sv
rtl/qau_back.sv
rtl/quaternion_arithmetic_unit.sv
sim/quaternion_arithmetic_unit_checker.sv
sim/quaternion_arithmetic_unit_tb.sv
